[rtl/cma_pkg.sv]
// Shared types and constants for the three-channel centered moving average.
// No dependencies; cma_lane and the top level refer to this package by scoped names.
package cma_pkg;

    // Window register width and its value after reset.
    localparam int WIN_BITS = 6;
    localparam logic [WIN_BITS-1:0] WIN_RESET = 6'd5;

    // Quotient bits retired per divider cycle.
    localparam int DIV_RADIX = 3;

    // Divider steps for one mean: magnitude bits plus one for the rounding offset, DIV_RADIX per step, rounded up.
    function automatic int div_steps(input int sample_bits, input int depth);
        return (sample_bits + $clog2(depth) + 1 + DIV_RADIX - 1) / DIV_RADIX;
    endfunction

    // Per-cycle commands from the sequencer to each channel lane.
    typedef struct packed {
        logic restart;  // first item of a frame: start the window sum from zero
        logic adjust;   // update the running window sum
        logic add_en;   // add the newly accepted sample
        logic sub_en;   // remove the sample read from the history
        logic load;     // load the divider from the window sum
        logic step;     // advance the divider by one step
    } lane_ctl_t;

endpackage

[rtl/cma_history.sv]
// Sample history ring: one entry holds the three channel samples of one item.
// Depends on nothing; instantiated by the top level.
module cma_history #(
    parameter int DATA_BITS = 72,
    parameter int DEPTH     = 64
) (
    input  logic                       aclk,
    input  logic                       wr_en,
    input  logic [$clog2(DEPTH)-1:0]   wr_addr,
    input  logic [DATA_BITS-1:0]       wr_data,
    input  logic                       rd_en,
    input  logic [$clog2(DEPTH)-1:0]   rd_addr,
    output logic [DATA_BITS-1:0]       rd_data
);

    logic [DATA_BITS-1:0] mem [DEPTH];

    // Read-first: a read of the address being written returns the old entry.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

endmodule

[rtl/cma_lane.sv]
// One channel lane: running window sum and a radix-8 restoring divider for the mean.
// Depends on cma_pkg; three copies are instantiated by the top level.
module cma_lane #(
    parameter int SAMPLE_BITS   = 24,
    parameter int HISTORY_DEPTH = 64
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  cma_pkg::lane_ctl_t                    ctl,
    input  logic signed [SAMPLE_BITS-1:0]         new_sample,
    input  logic signed [SAMPLE_BITS-1:0]         old_sample,
    input  logic [$clog2(HISTORY_DEPTH+1)-1:0]    count,
    output logic signed [SAMPLE_BITS-1:0]         mean
);

    localparam int CW       = $clog2(HISTORY_DEPTH + 1);
    localparam int SUM_BITS = SAMPLE_BITS + $clog2(HISTORY_DEPTH);
    localparam int STEPS    = cma_pkg::div_steps(SAMPLE_BITS, HISTORY_DEPTH);
    localparam int PAD      = STEPS * cma_pkg::DIV_RADIX;

    logic signed [SUM_BITS-1:0] sum_reg, sum_next;
    logic signed [SUM_BITS-1:0] base, add_term, sub_term;
    logic [SUM_BITS-1:0]        mag;
    logic [PAD-1:0]             dividend;
    logic [CW:0]                rem_reg, rem_next, r;
    logic [PAD-1:0]             dq_reg, dq_next, dq;
    logic                       ge;
    logic                       neg_reg;
    logic [SAMPLE_BITS-1:0]     q;

    // Window sum update: add the new sample and drop the one leaving the span.
    always_comb begin
        base     = ctl.restart ? '0 : sum_reg;
        add_term = ctl.add_en ? SUM_BITS'(new_sample) : '0;
        sub_term = ctl.sub_en ? SUM_BITS'(old_sample) : '0;
        sum_next = base + add_term - sub_term;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg <= '0;
        end else if (ctl.adjust) begin
            sum_reg <= sum_next;
        end
    end

    // Rounded magnitude to divide: |sum| + count/2 gives round half away from zero.
    always_comb begin
        mag      = sum_reg[SUM_BITS-1] ? SUM_BITS'(-sum_reg) : SUM_BITS'(sum_reg);
        dividend = PAD'(mag) + PAD'(count >> 1);
    end

    // Restoring division, DIV_RADIX quotient bits per cycle while step is set.
    always_comb begin
        r  = rem_reg;
        dq = dq_reg;
        ge = 1'b0;
        for (int k = 0; k < cma_pkg::DIV_RADIX; k++) begin
            r  = {r[CW-1:0], dq[PAD-1]};
            ge = (r >= {1'b0, count});
            dq = {dq[PAD-2:0], ge};
            if (ge) begin
                r = r - {1'b0, count};
            end
        end
        rem_next = r;
        dq_next  = dq;
    end

    always_ff @(posedge aclk) begin
        if (ctl.load) begin
            rem_reg <= '0;
            dq_reg  <= dividend;
            neg_reg <= sum_reg[SUM_BITS-1];
        end else if (ctl.step) begin
            rem_reg <= rem_next;
            dq_reg  <= dq_next;
        end
    end

    // Restore the sign of the quotient.
    assign q    = dq_reg[SAMPLE_BITS-1:0];
    assign mean = neg_reg ? signed'(-q) : signed'(q);

endmodule

[rtl/cma_merge.sv]
// Output stage: joins the three lane means and the last flag into one result request.
// Depends on nothing; instantiated by the top level.
module cma_merge #(
    parameter int SAMPLE_BITS = 24
) (
    input  logic                                      aclk,
    input  logic                                      aresetn,
    input  logic                                      push,
    input  logic                                      push_last,
    input  logic signed [SAMPLE_BITS-1:0]             mean_a,
    input  logic signed [SAMPLE_BITS-1:0]             mean_b,
    input  logic signed [SAMPLE_BITS-1:0]             mean_ab,
    output logic                                      slot_free,
    output logic                                      m_tvalid,
    input  logic                                      m_tready,
    // smoothed_a, smoothed_b, smoothed_ab from bit 0 up, zero padded to bytes
    output logic [((3*SAMPLE_BITS+7)/8)*8-1:0]        m_tdata,
    // result_last
    output logic                                      m_tlast
);

    localparam int TW = ((3 * SAMPLE_BITS + 7) / 8) * 8;

    logic                       valid_reg;
    logic [3*SAMPLE_BITS-1:0]   data_reg;
    logic                       last_reg;

    // The holding register frees as soon as its request is taken.
    assign slot_free = !valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (slot_free) begin
            valid_reg <= push;
        end
    end

    always_ff @(posedge aclk) begin
        if (slot_free && push) begin
            data_reg <= {mean_ab, mean_b, mean_a};
            last_reg <= push_last;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = TW'(data_reg);
    assign m_tlast  = last_reg;

endmodule

[rtl/centered_moving_average_three_channel.sv]
// An accepted item passes READ and ADJUST, then returns to IDLE if it gives no result; otherwise
// START, DIV (the 3-bit-per-cycle lane dividers) and PUSH follow. Items are taken only in IDLE.
// A frame end flushes up to half+1 results, each through READ to PUSH; PUSH waits on the slot.
// Reset (synchronous, active low) clears the window to 5, the frame count and window sums.
// The history memory has no reset; only entries written in the current frame are read.
module centered_moving_average_three_channel #(
    parameter int HISTORY_DEPTH = 64,
    parameter int SAMPLE_BITS   = 24
) (
    input  logic                                      aclk,
    input  logic                                      aresetn,
    input  logic                                      cfg_wr_en,
    input  logic [cma_pkg::WIN_BITS-1:0]              cfg_wr_data,
    input  logic                                      s_tvalid,
    output logic                                      s_tready,
    // sample_a, sample_b, sample_ab from bit 0 up, zero padded to bytes
    input  logic [((3*SAMPLE_BITS+7)/8)*8-1:0]        s_tdata,
    // frame_end
    input  logic                                      s_tlast,
    output logic                                      m_tvalid,
    input  logic                                      m_tready,
    // smoothed_a, smoothed_b, smoothed_ab from bit 0 up, zero padded to bytes
    output logic [((3*SAMPLE_BITS+7)/8)*8-1:0]        m_tdata,
    // result_last
    output logic                                      m_tlast
);

    localparam int AW    = $clog2(HISTORY_DEPTH);
    localparam int CW    = $clog2(HISTORY_DEPTH + 1);
    localparam int HMAX  = (HISTORY_DEPTH - 1) / 2;
    localparam int STEPS = cma_pkg::div_steps(SAMPLE_BITS, HISTORY_DEPTH);
    localparam int SW    = $clog2(STEPS + 1);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_READ   = 3'd1;
    localparam logic [2:0] S_ADJUST = 3'd2;
    localparam logic [2:0] S_START  = 3'd3;
    localparam logic [2:0] S_DIV    = 3'd4;
    localparam logic [2:0] S_PUSH   = 3'd5;

    logic [2:0]                     state_reg, state_next;
    logic [cma_pkg::WIN_BITS-1:0]   wp_reg;
    logic [AW-1:0]                  half_reg, idx_reg, head_reg, newest_reg, dk_reg;
    logic                           active_reg, flush_reg, upd_reg, restart_reg;
    logic                           fe_reg, sub_en_reg;
    logic [CW-1:0]                  cnt_reg;
    logic [SW-1:0]                  step_reg;
    logic signed [SAMPLE_BITS-1:0]  new_a_reg, new_b_reg, new_ab_reg;

    logic                           accept;
    logic [cma_pkg::WIN_BITS-1:0]   wp_eff, h_raw;
    logic [AW-1:0]                  h_new, idx_new;
    logic [AW:0]                    two_h1, dk_plus_h, d_back, addr_sum;
    logic [AW-1:0]                  base_addr, rd_addr;
    logic                           sub_cond;
    logic [AW-1:0]                  dk_sel, top;
    logic                           emit;
    logic [AW:0]                    hi, hi_c;
    logic                           slot_free, push, push_last;
    logic [3*SAMPLE_BITS-1:0]       rd_data;
    cma_pkg::lane_ctl_t             lane_ctl;
    logic signed [SAMPLE_BITS-1:0]  mean_a, mean_b, mean_ab;

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;

    // Window register; it takes effect at the next frame start.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg <= cma_pkg::WIN_RESET;
        end else if (cfg_wr_en) begin
            wp_reg <= cfg_wr_data;
        end
    end

    // Half width for a new frame: a zero window acts as one, clamped to the history.
    always_comb begin
        wp_eff = (wp_reg == '0) ? cma_pkg::WIN_BITS'(1) : wp_reg;
        h_raw  = wp_eff >> 1;
        h_new  = (32'(h_raw) > 32'(HMAX)) ? AW'(HMAX) : AW'(h_raw);
        if (!active_reg) begin
            idx_new = '0;
        end else if (idx_reg == AW'(HISTORY_DEPTH - 1)) begin
            idx_new = idx_reg;
        end else begin
            idx_new = idx_reg + 1'b1;
        end
    end

    // History address of the sample that leaves the span, and whether it exists.
    always_comb begin
        two_h1    = {half_reg, 1'b1};
        dk_plus_h = (AW+1)'(dk_reg) + (AW+1)'(half_reg);
        d_back    = upd_reg ? two_h1 : dk_plus_h;
        base_addr = upd_reg ? head_reg : newest_reg;
        sub_cond  = upd_reg ? ((AW+1)'(idx_reg) >= two_h1)
                            : (dk_plus_h <= (AW+1)'(idx_reg));
        addr_sum  = (AW+1)'(base_addr) + (AW+1)'(HISTORY_DEPTH) - d_back;
        if (addr_sum >= (AW+1)'(HISTORY_DEPTH)) begin
            addr_sum = addr_sum - (AW+1)'(HISTORY_DEPTH);
        end
        rd_addr = AW'(addr_sum);
    end

    // Center of the next result and the number of samples its span covers.
    always_comb begin
        top = (half_reg < idx_reg) ? half_reg : idx_reg;
        if (upd_reg) begin
            dk_sel = fe_reg ? top : half_reg;
            emit   = fe_reg || (idx_reg >= half_reg);
        end else begin
            dk_sel = dk_reg - 1'b1;
            emit   = 1'b1;
        end
        hi   = (AW+1)'(dk_sel) + (AW+1)'(half_reg);
        hi_c = (hi > (AW+1)'(idx_reg)) ? (AW+1)'(idx_reg) : hi;
    end

    assign push      = (state_reg == S_PUSH);
    assign push_last = flush_reg && (dk_reg == '0);

    // Sequencer next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:   if (accept) state_next = S_READ;
            S_READ:   state_next = S_ADJUST;
            S_ADJUST: state_next = emit ? S_START : S_IDLE;
            S_START:  state_next = S_DIV;
            S_DIV:    if (step_reg == SW'(STEPS - 1)) state_next = S_PUSH;
            S_PUSH: begin
                if (slot_free) begin
                    state_next = (flush_reg && dk_reg != '0) ? S_READ : S_IDLE;
                end
            end
            default:  state_next = S_IDLE;
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            half_reg    <= '0;
            idx_reg     <= '0;
            head_reg    <= '0;
            newest_reg  <= '0;
            dk_reg      <= '0;
            active_reg  <= 1'b0;
            flush_reg   <= 1'b0;
            upd_reg     <= 1'b0;
            restart_reg <= 1'b0;
            fe_reg      <= 1'b0;
            sub_en_reg  <= 1'b0;
            cnt_reg     <= '0;
            step_reg    <= '0;
        end else begin
            state_reg <= state_next;
            unique case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        if (!active_reg) begin
                            half_reg <= h_new;
                        end
                        idx_reg     <= idx_new;
                        active_reg  <= 1'b1;
                        restart_reg <= !active_reg;
                        upd_reg     <= 1'b1;
                        fe_reg      <= s_tlast;
                    end
                end
                S_READ: begin
                    sub_en_reg <= sub_cond;
                    if (upd_reg) begin
                        newest_reg <= head_reg;
                        head_reg   <= (head_reg == AW'(HISTORY_DEPTH - 1)) ? '0
                                                                         : head_reg + 1'b1;
                    end
                end
                S_ADJUST: begin
                    upd_reg     <= 1'b0;
                    restart_reg <= 1'b0;
                    dk_reg      <= dk_sel;
                    cnt_reg     <= CW'(hi_c) + 1'b1;
                    if (upd_reg && fe_reg) begin
                        flush_reg <= 1'b1;
                    end
                end
                S_START: begin
                    step_reg <= '0;
                end
                S_DIV: begin
                    step_reg <= step_reg + 1'b1;
                end
                S_PUSH: begin
                    if (slot_free && push_last) begin
                        flush_reg  <= 1'b0;
                        active_reg <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    // Accepted samples wait here until the lanes fold them into the sums.
    always_ff @(posedge aclk) begin
        if (accept) begin
            new_a_reg  <= s_tdata[SAMPLE_BITS-1:0];
            new_b_reg  <= s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
            new_ab_reg <= s_tdata[3*SAMPLE_BITS-1:2*SAMPLE_BITS];
        end
    end

    // History ring of sample triples.
    cma_history #(
        .DATA_BITS (3 * SAMPLE_BITS),
        .DEPTH     (HISTORY_DEPTH)
    ) u_history (
        .aclk    (aclk),
        .wr_en   ((state_reg == S_READ) && upd_reg),
        .wr_addr (head_reg),
        .wr_data ({new_ab_reg, new_b_reg, new_a_reg}),
        .rd_en   (state_reg == S_READ),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Commands shared by the three lanes.
    always_comb begin
        lane_ctl.restart = restart_reg;
        lane_ctl.adjust  = (state_reg == S_ADJUST);
        lane_ctl.add_en  = upd_reg;
        lane_ctl.sub_en  = sub_en_reg;
        lane_ctl.load    = (state_reg == S_START);
        lane_ctl.step    = (state_reg == S_DIV);
    end

    cma_lane #(
        .SAMPLE_BITS   (SAMPLE_BITS),
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_lane_a (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctl        (lane_ctl),
        .new_sample (new_a_reg),
        .old_sample (rd_data[SAMPLE_BITS-1:0]),
        .count      (cnt_reg),
        .mean       (mean_a)
    );

    cma_lane #(
        .SAMPLE_BITS   (SAMPLE_BITS),
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_lane_b (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctl        (lane_ctl),
        .new_sample (new_b_reg),
        .old_sample (rd_data[2*SAMPLE_BITS-1:SAMPLE_BITS]),
        .count      (cnt_reg),
        .mean       (mean_b)
    );

    cma_lane #(
        .SAMPLE_BITS   (SAMPLE_BITS),
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_lane_ab (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctl        (lane_ctl),
        .new_sample (new_ab_reg),
        .old_sample (rd_data[3*SAMPLE_BITS-1:2*SAMPLE_BITS]),
        .count      (cnt_reg),
        .mean       (mean_ab)
    );

    // Output register joining the lane means.
    cma_merge #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_merge (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_last (push_last),
        .mean_a    (mean_a),
        .mean_b    (mean_b),
        .mean_ab   (mean_ab),
        .slot_free (slot_free),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    // A flush never centers a result beyond the half width or the frame start.
    a_flush_center: assert property (@(posedge aclk) disable iff (!aresetn)
        flush_reg |-> (dk_reg <= half_reg) && (dk_reg <= idx_reg))
        else $error("flush center out of range");

    // The divisor is never zero and never exceeds the full span.
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DIV) |-> (cnt_reg != '0) &&
            ((AW+2)'(cnt_reg) <= (AW+2)'({half_reg, 1'b1})))
        else $error("divisor count out of range");

    // The first item of a frame restarts the index and the window sums.
    a_frame_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && !active_reg) |=> (idx_reg == '0) && restart_reg && active_reg)
        else $error("frame start not taken");

    // Handing over the final result of a frame closes the frame.
    a_frame_close: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && slot_free && push_last) |=> !active_reg && !flush_reg)
        else $error("frame not closed after final result");

endmodule
